/* rtl/core/tdf_pkg.sv */
package tdf_pkg;

   localparam int TDF_VALUE_WIDTH  = 32;
   localparam int TDF_FACTOR_WIDTH = 32;
   localparam int TDF_MAX_RESULTS  = 32;
   localparam int TDF_COUNT_WIDTH  = $clog2(TDF_MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_SMALL,
      ST_TWOS,
      ST_TEST,
      ST_DIV,
      ST_TAIL,
      ST_FLUSH
   } tdf_state_type;

   typedef enum logic [1:0] {
      SEL_MINUS_ONE,
      SEL_MAG,
      SEL_TWO,
      SEL_DIVISOR
   } tdf_sel_type;

   typedef struct packed {
      logic        load;
      logic        push;
      tdf_sel_type push_sel;
      logic        shift;
      logic        div_start;
      logic        div_accept;
      logic        step_divisor;
      logic        flush;
   } tdf_cmd_type;

   typedef struct packed {
      logic neg;
      logic small_mag;
      logic mag_odd;
      logic sq_gt_mag;
      logic div_done;
      logic div_exact;
      logic mag_gt1;
   } tdf_status_type;

endpackage

/* rtl/core/tdf_divider.sv */
module tdf_divider #(
   parameter int VALUE_WIDTH   = tdf_pkg::TDF_VALUE_WIDTH,
   parameter int DIVISOR_WIDTH = (tdf_pkg::TDF_VALUE_WIDTH + 1) / 2 + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [VALUE_WIDTH-1:0]   dividend,
   input  logic [DIVISOR_WIDTH-1:0] divisor,
   output logic [VALUE_WIDTH-1:0]   quotient,
   output logic [DIVISOR_WIDTH-1:0] remainder,
   output logic                     done
);
   import tdf_pkg::*;

   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic                     busy_ff;
   logic                     done_ff;
   logic [CW-1:0]            cnt_ff;
   logic [VALUE_WIDTH-1:0]   quo_ff;
   logic [DIVISOR_WIDTH-1:0] rem_ff;
   logic [DIVISOR_WIDTH-1:0] div_ff;
   logic [DIVISOR_WIDTH:0]   shifted;
   logic [DIVISOR_WIDTH:0]   diff;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(VALUE_WIDTH);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_WIDTH]) begin
            rem_ff <= diff[DIVISOR_WIDTH-1:0];
            quo_ff <= {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DIVISOR_WIDTH-1:0];
            quo_ff <= {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

/* rtl/core/tdf_datapath.sv */
module tdf_datapath #(
   parameter int VALUE_WIDTH = tdf_pkg::TDF_VALUE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tdf_pkg::tdf_cmd_type                   cmd,
   input  logic signed [31:0]                     number,
   output tdf_pkg::tdf_status_type                status,
   output logic                                   rsp_strobe,
   output logic signed [tdf_pkg::TDF_FACTOR_WIDTH-1:0] rsp_factor_value,
   output logic                                   rsp_last_factor
);
   import tdf_pkg::*;

   localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
   localparam int SW = 2 * DW;

   logic [VALUE_WIDTH-1:0]      mag_ff, mag_in;
   logic                        neg_ff, neg_in;
   logic [DW-1:0]               d_ff, d_in;
   logic [SW-1:0]               sq_ff, sq_in;
   logic [TDF_FACTOR_WIDTH-1:0] pend_ff, pend_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [TDF_COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                        strobe_ff, strobe_in;
   logic [TDF_FACTOR_WIDTH-1:0] value_ff, value_in;
   logic                        last_ff, last_in;

   logic [63:0]                 num_wide;
   logic [VALUE_WIDTH-1:0]      raw;
   logic [63:0]                 mag_wide;
   logic [63:0]                 d_wide;
   logic [TDF_FACTOR_WIDTH-1:0] push_value;
   logic                        room;
   logic [VALUE_WIDTH-1:0]      quotient;
   logic [DW-1:0]               div_rem;
   logic                        div_done;

   // a restart after an exact division must see the new quotient, hence mag_in
   tdf_divider #(
      .VALUE_WIDTH  (VALUE_WIDTH),
      .DIVISOR_WIDTH(DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag_in),
      .divisor  (d_ff),
      .quotient (quotient),
      .remainder(div_rem),
      .done     (div_done)
   );

   assign num_wide = 64'($unsigned(number));
   assign raw      = num_wide[VALUE_WIDTH-1:0];
   assign mag_wide = 64'(mag_ff);
   assign d_wide   = 64'(d_ff);

   always_comb begin
      case (cmd.push_sel)
         SEL_MINUS_ONE: push_value = '1;
         SEL_MAG:       push_value = mag_wide[TDF_FACTOR_WIDTH-1:0];
         SEL_TWO:       push_value = TDF_FACTOR_WIDTH'(2);
         SEL_DIVISOR:   push_value = d_wide[TDF_FACTOR_WIDTH-1:0];
         default:       push_value = '0;
      endcase
   end

   // results beyond the limit are dropped
   assign room = ({1'b0, count_ff} + (TDF_COUNT_WIDTH + 1)'(pend_valid_ff))
                 < (TDF_COUNT_WIDTH + 1)'(TDF_MAX_RESULTS);

   always_comb begin
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      count_in      = count_ff;
      strobe_in     = 1'b0;
      value_in      = value_ff;
      last_in       = last_ff;
      if (cmd.load) begin
         neg_in        = raw[VALUE_WIDTH-1];
         mag_in        = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
         d_in          = DW'(3);
         sq_in         = SW'(9);
         pend_valid_in = 1'b0;
         count_in      = '0;
      end
      if (cmd.shift) begin
         mag_in = {1'b0, mag_ff[VALUE_WIDTH-1:1]};
      end
      if (cmd.div_accept) begin
         mag_in = quotient;
      end
      if (cmd.step_divisor) begin
         // (d + 2)^2 = d^2 + 4d + 4
         d_in  = d_ff + DW'(2);
         sq_in = sq_ff + SW'({d_ff, 2'b00}) + SW'(4);
      end
      if (cmd.push && room) begin
         if (pend_valid_ff) begin
            strobe_in = 1'b1;
            value_in  = pend_ff;
            last_in   = 1'b0;
            count_in  = count_ff + TDF_COUNT_WIDTH'(1);
         end
         pend_in       = push_value;
         pend_valid_in = 1'b1;
      end
      if (cmd.flush && pend_valid_ff) begin
         strobe_in     = 1'b1;
         value_in      = pend_ff;
         last_in       = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      pend_ff  <= pend_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign status.neg       = neg_ff;
   assign status.small_mag = mag_ff < VALUE_WIDTH'(4);
   assign status.mag_odd   = mag_ff[0];
   assign status.sq_gt_mag = sq_ff > SW'(mag_ff);
   assign status.div_done  = div_done;
   assign status.div_exact = div_rem == '0;
   assign status.mag_gt1   = mag_ff > VALUE_WIDTH'(1);

   assign rsp_strobe       = strobe_ff;
   assign rsp_factor_value = value_ff;
   assign rsp_last_factor  = last_ff;

endmodule

/* rtl/core/tdf_controller.sv */
module tdf_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  tdf_pkg::tdf_status_type status,
   output tdf_pkg::tdf_cmd_type    cmd,
   output logic                    busy
);
   import tdf_pkg::*;

   tdf_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SIGN;
         ST_SIGN:  state_in = ST_SMALL;
         ST_SMALL: state_in = status.small_mag ? ST_FLUSH : ST_TWOS;
         ST_TWOS:  if (status.mag_odd) state_in = ST_TEST;
         ST_TEST:  state_in = status.sq_gt_mag ? ST_TAIL : ST_DIV;
         ST_DIV:   if (status.div_done && !status.div_exact) state_in = ST_TEST;
         ST_TAIL:  state_in = ST_FLUSH;
         ST_FLUSH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.push_sel = SEL_MAG;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_SIGN: begin
            cmd.push     = status.neg;
            cmd.push_sel = SEL_MINUS_ONE;
         end
         ST_SMALL: begin
            cmd.push     = status.small_mag;
            cmd.push_sel = SEL_MAG;
         end
         ST_TWOS: begin
            cmd.push     = !status.mag_odd;
            cmd.push_sel = SEL_TWO;
            cmd.shift    = !status.mag_odd;
         end
         ST_TEST: begin
            cmd.div_start = !status.sq_gt_mag;
         end
         ST_DIV: begin
            // exact: take the quotient and try the same divisor again
            if (status.div_done) begin
               if (status.div_exact) begin
                  cmd.push       = 1'b1;
                  cmd.push_sel   = SEL_DIVISOR;
                  cmd.div_accept = 1'b1;
                  cmd.div_start  = 1'b1;
               end else begin
                  cmd.step_divisor = 1'b1;
               end
            end
         end
         ST_TAIL: begin
            cmd.push     = status.mag_gt1;
            cmd.push_sel = SEL_MAG;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

/* rtl/core/trial_division_factorizer.sv */
// channel   ports                                     handshake
// request   req_number                                start & !busy
// result    rsp_factor_value, rsp_last_factor         rsp_strobe, one cycle, no stall
//
// busy lasts through the sign and size checks, the trailing zero bits, one division per odd divisor tried
// and one more per odd factor divided out; a magnitude below 4 goes straight to the flush
// odd divisors stop at the square root of the cofactor: about 46341 for a prime near 2^31
// synchronous reset returns the controller to idle and clears the result strobe
// a factor is held until the next one is found, so the final one can be marked
// the receiver takes each result in its strobe cycle
module trial_division_factorizer #(
   parameter int VALUE_WIDTH = tdf_pkg::TDF_VALUE_WIDTH
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic signed [31:0]                          req_number,
   output logic                                        rsp_strobe,
   output logic signed [tdf_pkg::TDF_FACTOR_WIDTH-1:0] rsp_factor_value,
   output logic                                        rsp_last_factor
);
   import tdf_pkg::*;

   tdf_cmd_type    cmd;
   tdf_status_type status;

   tdf_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .status(status),
      .cmd   (cmd),
      .busy  (busy)
   );

   tdf_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .number          (req_number),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_factor_value(rsp_factor_value),
      .rsp_last_factor (rsp_last_factor)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_factor |=> !rsp_strobe)
      else $error("result right after the last factor");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_factor |-> busy)
      else $error("non-final result while idle");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> busy)
      else $error("divider finished while idle");

endmodule

/* tb/sv/tb_trial_division_factorizer.sv */
`timescale 1ns / 100ps

module tb_trial_division_factorizer;

   localparam int CALM_TAIL       = 20;
   localparam int RANDOM_REQUESTS = 75;
   localparam int DRAIN_CYCLES    = 60;
   // a prime near 2^31 keeps the block silent through every odd divisor up to its square root
   localparam int WATCHDOG_LIMIT  = 3_000_000;

   typedef struct {
      logic signed [31:0] value;
      logic               last;
   } factor_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                start      = 1'b0;
   logic signed [31:0]  req_number = '0;
   logic                busy;
   logic                rsp_strobe;
   logic signed [tdf_pkg::TDF_FACTOR_WIDTH-1:0] rsp_factor_value;
   logic                rsp_last_factor;

   logic [31:0] numbers_waiting[$];
   factor_type  factors_due[$];
   int          hold_off        = 0;
   int          requests_done   = 0;
   int          negative_count  = 0;
   int          factors_checked = 0;
   int          mismatches      = 0;
   int          idle_cycles     = 0;
   int          request_total   = 0;

   // zero, one, small magnitudes, prime squares, powers of two, both extremes
   int directed_numbers[$] = '{0, 1, 2, 3, -1, -2, -3, 4, 5, 6, 8, 9, 15, 25, 27,
      9409, 65521, -360360, 1047552, 999999999, 1073741824, -1073741824,
      2147483646, 32'sh8000_0000, 32'sh7FFF_FFFF};

   trial_division_factorizer DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_number       (req_number),
      .rsp_strobe       (rsp_strobe),
      .rsp_factor_value (rsp_factor_value),
      .rsp_last_factor  (rsp_last_factor)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void predict_factors(input logic [31:0] number);
      logic [31:0]     mag;
      longint unsigned rest;
      longint unsigned divisor;
      logic [31:0]     vals[$];
      factor_type      entry;
      int              kept;
      if (number[31]) begin
         vals.push_back(32'hFFFF_FFFF);
         mag = -number;
      end else begin
         mag = number;
      end
      rest = mag;
      if (rest < 4) begin
         vals.push_back(rest[31:0]);
      end else begin
         while (rest[0] == 1'b0) begin
            vals.push_back(32'd2);
            rest = rest >> 1;
         end
         divisor = 3;
         while (divisor <= rest / divisor) begin
            while (rest % divisor == 0) begin
               vals.push_back(divisor[31:0]);
               rest = rest / divisor;
            end
            divisor = divisor + 2;
         end
         if (rest > 1)
            vals.push_back(rest[31:0]);
      end
      // overflow of the result count drops later factors
      kept = (vals.size() > tdf_pkg::TDF_MAX_RESULTS) ? tdf_pkg::TDF_MAX_RESULTS : vals.size();
      for (int i = 0; i < kept; i++) begin
         entry.value = vals[i];
         entry.last  = (i == kept - 1);
         factors_due.push_back(entry);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         req_number <= '0;
         hold_off   <= 0;
      end else if (start && !busy) begin
         predict_factors(req_number);
         requests_done++;
         if (req_number < 0)
            negative_count++;
         if (numbers_waiting.size() == 0) begin
            start <= 1'b0;
         end else if (numbers_waiting.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
            start    <= 1'b0;
            hold_off <= $urandom_range(1, 4);
         end else begin
            start      <= 1'b1;
            req_number <= numbers_waiting.pop_front();
         end
      end else if (!start) begin
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
         end else if (numbers_waiting.size() != 0) begin
            start      <= 1'b1;
            req_number <= numbers_waiting.pop_front();
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      factor_type due;
      if (!reset && rsp_strobe) begin
         if (factors_due.size() == 0) begin
            $error("unexpected factor: factor_value %0d last_factor %0d",
                   rsp_factor_value, rsp_last_factor);
            mismatches++;
         end else begin
            due = factors_due.pop_front();
            factors_checked++;
            if (rsp_factor_value !== due.value) begin
               $error("factor_value: expected %0d, actual %0d", due.value, rsp_factor_value);
               mismatches++;
            end
            if (rsp_last_factor !== due.last) begin
               $error("last_factor: expected %0d, actual %0d", due.last, rsp_last_factor);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d factors outstanding", factors_due.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      longint unsigned product;
      int unsigned     pick;
      int unsigned     multiplier;
      logic [31:0]     number;
      foreach (directed_numbers[i])
         numbers_waiting.push_back(directed_numbers[i]);
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            // smooth numbers reach the high bits yet factor quickly
            product = 1;
            repeat ($urandom_range(1, 14)) begin
               multiplier = $urandom_range(2, 257);
               if (product * multiplier < 64'h8000_0000)
                  product = product * multiplier;
            end
            number = product[31:0];
         end else if (pick < 15) begin
            number = $urandom_range(0, 65535);
         end else begin
            number = $urandom_range(0, 8);
         end
         if ($urandom_range(0, 1) == 1)
            number = -number;
         numbers_waiting.push_back(number);
      end
      request_total = numbers_waiting.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (requests_done < request_total)
         @(posedge clock);
      while (factors_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests factored, %0d of them negative", requests_done, negative_count);
      $display("%0d factors compared against the prediction", factors_checked);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
